>>> hdl/bti_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bti_pkg: shared types and constants
// Command codes, sequencer states and fixed-point constants.
// ----------------------------------------------------------------------------
package bti_pkg;

    localparam logic [1:0] CMD_WR_PHASE = 2'd0;
    localparam logic [1:0] CMD_WR_VEL   = 2'd1;
    localparam logic [1:0] CMD_WR_TAB   = 2'd2;
    localparam logic [1:0] CMD_QUERY    = 2'd3;

    localparam logic [0:0] REG_PHASE_USED = 1'b0;
    localparam logic [0:0] REG_VEL_USED   = 1'b1;

    localparam logic signed [31:0] TWO_PI_Q16 = 32'sd411775;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_VRD,      // read velocity breakpoints 0 and nv-1
        ST_VWAIT,
        ST_VSRCH,    // ascending velocity search
        ST_VSWAIT,
        ST_COLSTART, // phase lookup for one column
        ST_PSCAN,    // min/max over phase breakpoints
        ST_PSWAIT,
        ST_PSRCH,    // ascending phase search
        ST_PSRWAIT,
        ST_TRD0,
        ST_TWAIT0,
        ST_TRD1,
        ST_TWAIT1,
        ST_PBLEND,   // start blend along phase
        ST_PBWAIT,
        ST_COLDONE,
        ST_VBLEND,
        ST_VBWAIT,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic        start;
        logic [63:0] x;
        logic [63:0] xa;
        logic [63:0] xb;
        logic [63:0] ya;
        logic [63:0] yb;
    } t_blend_req;

endpackage

>>> hdl/bti_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bti_ram: generic single-port RAM
// One write or one read per cycle, registered read data.
// ----------------------------------------------------------------------------
module bti_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

>>> hdl/bti_blend.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bti_blend: shared linear blend unit
// Restoring divider for the fraction, then one multiply and saturation.
// ----------------------------------------------------------------------------
module bti_blend
    import bti_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_blend_req        i_req,
    output logic              o_done,
    output logic signed [31:0] o_result
);
    logic [5:0]         r_cnt, n_cnt;
    logic [1:0]         r_ph, n_ph;
    logic [49:0]        r_num, n_num;
    logic [33:0]        r_den, n_den;
    logic [33:0]        r_rem, n_rem;
    logic signed [33:0] r_dy, n_dy;
    logic signed [63:0] r_ya, n_ya;
    logic signed [51:0] r_prod, n_prod;
    logic               r_zero, n_zero;
    logic               r_done, n_done;
    logic signed [31:0] r_res, n_res;

    logic signed [63:0] s_dx, s_den;
    logic [34:0]        s_trial;
    logic [16:0]        s_f;
    logic signed [63:0] s_q, s_r;

    always_comb begin
        s_dx  = $signed(i_req.x) - $signed(i_req.xa);
        s_den = $signed(i_req.xb) - $signed(i_req.xa);
        s_trial = {r_rem, r_num[49]} - {1'b0, r_den};
        // fraction: saturate to 0..65536 (quotient only 50 bits wide)
        s_f = (r_zero || r_num == '0) ? 17'd0 :
              (r_num[49:17] != '0) ? 17'h10000 :
              (r_num[16:0] > 17'h10000) ? 17'h10000 : r_num[16:0];
        s_q = 64'(r_prod >>> 16);
        s_r = r_ya + s_q;
    end

    always_comb begin
        n_cnt = r_cnt; n_ph = r_ph; n_num = r_num; n_den = r_den; n_rem = r_rem;
        n_dy = r_dy; n_ya = r_ya; n_prod = r_prod; n_zero = r_zero;
        n_done = 1'b0; n_res = r_res;
        case (r_ph)
            2'd0: begin
                if (i_req.start) begin
                    n_dy = 34'($signed(i_req.yb) - $signed(i_req.ya));
                    n_ya = $signed(i_req.ya);
                    n_den = s_den[33:0];
                    n_zero = (s_den <= 0) || (s_dx <= 0);
                    // dx < 2^33 so dx<<16 fits in 50 bits
                    n_num = {s_dx[33:0], 16'd0};
                    n_rem = '0;
                    n_cnt = 6'd50;
                    n_ph = 2'd1;
                end
            end
            2'd1: begin
                if (!s_trial[34]) begin
                    n_rem = s_trial[33:0];
                    n_num = {r_num[48:0], 1'b1};
                end else begin
                    n_rem = {r_rem[32:0], r_num[49]};
                    n_num = {r_num[48:0], 1'b0};
                end
                n_cnt = r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    n_ph = 2'd2;
                end
            end
            2'd2: begin
                n_prod = 52'($signed({1'b0, s_f})) * 52'(r_dy);
                n_ph = 2'd3;
            end
            default: begin
                if (s_r > 64'sd2147483647) begin
                    n_res = 32'sh7fffffff;
                end else if (s_r < -64'sd2147483648) begin
                    n_res = 32'sh80000000;
                end else begin
                    n_res = s_r[31:0];
                end
                n_done = 1'b1;
                n_ph = 2'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph <= 2'd0;
            r_done <= 1'b0;
        end else begin
            r_ph <= n_ph;
            r_done <= n_done;
        end
        r_cnt <= n_cnt; r_num <= n_num; r_den <= n_den; r_rem <= n_rem;
        r_dy <= n_dy; r_ya <= n_ya; r_prod <= n_prod; r_zero <= n_zero;
        r_res <= n_res;
    end

    assign o_done = r_done;
    assign o_result = r_res;

    ap_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done) else $error("blend done held");
    ap_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ph == 2'd1 && r_cnt == 6'd1) |=> r_ph == 2'd2)
        else $error("divider did not finish");
    ap_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ph == 2'd1 |-> r_cnt != 6'd0) else $error("divider count underflow");
endmodule

>>> hdl/bilinear_table_interpolator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bilinear_table_interpolator: 2-D table interpolation on a non-uniform grid
// Loads breakpoints and table entries, answers bilinear queries.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake          | Payload
// cfg     | in        | i_cfg_valid/ready  | i_cfg_index, i_cfg_data
// request | in        | i_valid/o_ready    | command, indexes, values
// result  | out       | o_valid/i_ready    | o_interp_value
//
// A query walks the velocity breakpoints once, then per column (one or
// two) scans all phase breakpoints for min/max, searches again and reads
// one entry, or reads two entries and runs the shared blend unit (its
// bit-serial 50-step divider) when the phase lies between breakpoints.
// Reset is synchronous, active low; memories are not cleared.
// A held result blocks new requests until taken.
// ----------------------------------------------------------------------------
module bilinear_table_interpolator
    import bti_pkg::*;
#(
    parameter int MAX_PHASE_POINTS    = 64,
    parameter int MAX_VELOCITY_POINTS = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [0:0]         i_cfg_index,
    input  logic [6:0]         i_cfg_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_command,
    input  logic [5:0]         i_row_index,
    input  logic [5:0]         i_col_index,
    input  logic signed [31:0] i_write_value,
    input  logic signed [31:0] i_query_phase,
    input  logic signed [31:0] i_query_velocity,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_interp_value
);
    localparam int PW = $clog2(MAX_PHASE_POINTS);
    localparam int VW = $clog2(MAX_VELOCITY_POINTS);
    localparam int TW = PW + VW;

    t_state r_state, n_state;
    logic [6:0] r_np_reg, r_nv_reg;
    logic [PW:0] s_np;
    logic [VW:0] s_nv;
    logic [PW:0] r_pi, n_pi;
    logic [VW:0] r_vi, n_vi;
    logic [VW-1:0] r_col, n_col;
    logic        r_second, n_second;
    logic signed [31:0] r_ph, n_ph, r_v, n_v;
    logic signed [31:0] r_vmin, n_vmin, r_va, n_va, r_vb, n_vb;
    logic signed [31:0] r_pmin, n_pmin, r_pmax, n_pmax, r_pa, n_pa, r_pb, n_pb;
    logic signed [31:0] r_ta, n_ta, r_tb, n_tb, r_lo, n_lo, r_hi, n_hi;
    logic signed [31:0] r_out, n_out;
    logic [PW-1:0] r_row, n_row;
    logic        r_direct, n_direct;
    logic        r_vdirect, n_vdirect;

    logic          s_pwe, s_vwe, s_twe;
    logic [PW-1:0] s_paddr;
    logic [VW-1:0] s_vaddr;
    logic [TW-1:0] s_taddr;
    logic signed [31:0] s_prd, s_vrd, s_trd;
    t_blend_req    s_breq;
    logic          s_bdone;
    logic signed [31:0] s_bres;
    logic          s_acc;

    // clamp used counts to 2..max
    always_comb begin
        s_np = (r_np_reg < 7'd2) ? (PW+1)'(2) :
               (32'(r_np_reg) > MAX_PHASE_POINTS) ? (PW+1)'(MAX_PHASE_POINTS) :
               (PW+1)'(r_np_reg);
        s_nv = (r_nv_reg < 7'd2) ? (VW+1)'(2) :
               (32'(r_nv_reg) > MAX_VELOCITY_POINTS) ? (VW+1)'(MAX_VELOCITY_POINTS) :
               (VW+1)'(r_nv_reg);
    end

    assign o_cfg_ready = (r_state == ST_IDLE);
    assign s_acc = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_np_reg <= 7'd2;
            r_nv_reg <= 7'd2;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == REG_PHASE_USED) r_np_reg <= i_cfg_data;
            else r_nv_reg <= i_cfg_data;
        end
    end

    // next-state logic
    always_comb begin
        n_state = r_state;
        n_pi = r_pi; n_vi = r_vi; n_col = r_col; n_second = r_second;
        n_ph = r_ph; n_v = r_v; n_vmin = r_vmin;
        n_va = r_va; n_vb = r_vb; n_pmin = r_pmin; n_pmax = r_pmax;
        n_pa = r_pa; n_pb = r_pb; n_ta = r_ta; n_tb = r_tb;
        n_lo = r_lo; n_hi = r_hi; n_out = r_out; n_row = r_row;
        n_direct = r_direct; n_vdirect = r_vdirect;
        case (r_state)
            ST_IDLE: begin
                if (s_acc && i_command == CMD_QUERY) begin
                    n_ph = (i_query_phase < 0) ? 32'sd0 :
                           (i_query_phase > TWO_PI_Q16) ? TWO_PI_Q16 : i_query_phase;
                    n_v = i_query_velocity;
                    n_state = ST_VRD;
                end
            end
            ST_VRD: n_state = ST_VWAIT;      // address r_vi presented
            ST_VWAIT: begin
                // first visit (r_vi zero): vmin ready; second visit: vmax
                if (r_vi == '0) begin
                    n_vmin = s_vrd;
                    n_vi = s_nv - 1'b1;
                    n_state = ST_VRD;
                end else begin
                    n_vi = '0;
                    n_second = 1'b0;
                    if (r_v >= s_vrd) begin
                        n_col = VW'(s_nv - 1'b1);
                        n_vdirect = 1'b1;
                        n_state = ST_COLSTART;
                    end else if (r_v <= r_vmin) begin
                        n_col = '0;
                        n_vdirect = 1'b1;
                        n_state = ST_COLSTART;
                    end else begin
                        n_vdirect = 1'b0;
                        n_state = ST_VSRCH;
                    end
                end
            end
            ST_VSRCH: n_state = ST_VSWAIT;
            ST_VSWAIT: begin
                if (r_vi < s_nv - 1'b1 && r_v >= s_vrd) begin
                    n_va = s_vrd;
                    n_vi = r_vi + 1'b1;
                    n_state = ST_VSRCH;
                end else begin
                    if (r_vi == '0) begin
                        // bracket at 1: need bp0 and bp1, bp0 is vmin
                        n_va = r_vmin;
                        n_vi = (VW+1)'(1);
                        n_state = ST_VSRCH;
                    end else begin
                        n_vb = s_vrd;
                        n_col = VW'(r_vi - 1'b1);
                        n_state = ST_COLSTART;
                    end
                end
            end
            ST_COLSTART: begin
                n_pi = '0;
                n_state = ST_PSCAN;
            end
            ST_PSCAN: n_state = ST_PSWAIT;
            ST_PSWAIT: begin
                if (r_pi == '0) begin
                    n_pmin = s_prd; n_pmax = s_prd;
                end else begin
                    if (s_prd > r_pmax) n_pmax = s_prd;
                    if (s_prd < r_pmin) n_pmin = s_prd;
                end
                if (r_pi == s_np - 1'b1) begin
                    n_pi = '0;
                    n_state = ST_PSRCH;
                end else begin
                    n_pi = r_pi + 1'b1;
                    n_state = ST_PSCAN;
                end
            end
            ST_PSRCH: begin
                if (r_ph >= r_pmax) begin
                    n_row = PW'(s_np - 1'b1); n_direct = 1'b1; n_state = ST_TRD0;
                end else if (r_ph <= r_pmin) begin
                    n_row = '0; n_direct = 1'b1; n_state = ST_TRD0;
                end else begin
                    n_direct = 1'b0;
                    n_state = ST_PSRWAIT;
                end
            end
            ST_PSRWAIT: begin
                // a phase below breakpoint 0 forces the bracket at 1: stop there
                if (r_pi < s_np - 1'b1 && r_ph >= s_prd &&
                    (r_pi == '0 || r_ph >= r_pa)) begin
                    n_pa = s_prd;
                    n_pi = r_pi + 1'b1;
                    n_state = ST_PSRCH;
                end else if (r_pi == '0) begin
                    n_pa = s_prd;
                    n_pi = (PW+1)'(1);
                    n_state = ST_PSRCH;
                end else begin
                    n_pb = s_prd;
                    n_row = PW'(r_pi - 1'b1);
                    n_state = ST_TRD0;
                end
            end
            ST_TRD0: n_state = ST_TWAIT0;
            ST_TWAIT0: begin
                n_ta = s_trd;
                if (r_direct) n_state = ST_COLDONE;
                else n_state = ST_TRD1;
            end
            ST_TRD1: n_state = ST_TWAIT1;
            ST_TWAIT1: begin
                n_tb = s_trd;
                n_state = ST_PBLEND;
            end
            ST_PBLEND: n_state = ST_PBWAIT;
            ST_PBWAIT: begin
                if (s_bdone) begin
                    n_ta = s_bres;
                    n_state = ST_COLDONE;
                end
            end
            ST_COLDONE: begin
                if (r_vdirect) begin
                    n_out = r_ta;
                    n_state = ST_OUT;
                end else if (!r_second) begin
                    n_lo = r_ta;
                    n_second = 1'b1;
                    n_col = r_col + 1'b1;
                    n_state = ST_COLSTART;
                end else begin
                    n_hi = r_ta;
                    n_state = ST_VBLEND;
                end
            end
            ST_VBLEND: n_state = ST_VBWAIT;
            ST_VBWAIT: begin
                if (s_bdone) begin
                    n_out = s_bres;
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (i_ready) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
        // the PSRCH state also issues a read; step pi through search reads
    end

    // output / memory control logic
    always_comb begin
        s_pwe = 1'b0; s_vwe = 1'b0; s_twe = 1'b0;
        s_paddr = PW'(r_pi);
        s_vaddr = VW'(r_vi);
        s_taddr = {r_row, r_col};
        s_breq = '0;
        o_ready = 1'b0;
        o_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                s_paddr = PW'(i_row_index);
                s_vaddr = VW'(i_col_index);
                s_taddr = {PW'(i_row_index), VW'(i_col_index)};
                // drop writes whose index lies beyond the table
                s_pwe = s_acc && i_command == CMD_WR_PHASE &&
                        32'(i_row_index) < MAX_PHASE_POINTS;
                s_vwe = s_acc && i_command == CMD_WR_VEL &&
                        32'(i_col_index) < MAX_VELOCITY_POINTS;
                s_twe = s_acc && i_command == CMD_WR_TAB &&
                        32'(i_row_index) < MAX_PHASE_POINTS &&
                        32'(i_col_index) < MAX_VELOCITY_POINTS;
            end
            ST_TRD1: s_taddr = {PW'(r_row + 1'b1), r_col};
            ST_PBLEND: begin
                s_breq.start = 1'b1;
                s_breq.x = 64'(r_ph); s_breq.xa = 64'(r_pa); s_breq.xb = 64'(r_pb);
                s_breq.ya = 64'(r_ta); s_breq.yb = 64'(r_tb);
            end
            ST_VBLEND: begin
                s_breq.start = 1'b1;
                s_breq.x = 64'(r_v); s_breq.xa = 64'(r_va); s_breq.xb = 64'(r_vb);
                s_breq.ya = 64'(r_lo); s_breq.yb = 64'(r_hi);
            end
            ST_OUT: o_valid = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_vi <= '0;
            r_pi <= '0;
            r_second <= 1'b0;
        end else begin
            r_state <= n_state;
            r_vi <= (r_state == ST_IDLE) ? '0 : n_vi;
            r_pi <= n_pi;
            r_second <= n_second;
        end
        r_col <= n_col; r_ph <= n_ph; r_v <= n_v;
        r_vmin <= n_vmin; r_va <= n_va; r_vb <= n_vb;
        r_pmin <= n_pmin; r_pmax <= n_pmax; r_pa <= n_pa; r_pb <= n_pb;
        r_ta <= n_ta; r_tb <= n_tb; r_lo <= n_lo; r_hi <= n_hi;
        r_out <= n_out; r_row <= n_row; r_direct <= n_direct;
        r_vdirect <= n_vdirect;
    end

    assign o_interp_value = r_out;

    bti_ram #(.WIDTH(32), .DEPTH(MAX_PHASE_POINTS)) u_phase_ram (
        .i_clk(i_clk), .i_we(s_pwe), .i_addr(s_paddr),
        .i_wdata(i_write_value), .o_rdata(s_prd));
    bti_ram #(.WIDTH(32), .DEPTH(MAX_VELOCITY_POINTS)) u_vel_ram (
        .i_clk(i_clk), .i_we(s_vwe), .i_addr(s_vaddr),
        .i_wdata(i_write_value), .o_rdata(s_vrd));
    bti_ram #(.WIDTH(32), .DEPTH(2 ** TW)) u_tab_ram (
        .i_clk(i_clk), .i_we(s_twe), .i_addr(s_taddr),
        .i_wdata(i_write_value), .o_rdata(s_trd));

    bti_blend u_blend (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(s_breq),
        .o_done(s_bdone), .o_result(s_bres));

    ap_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_interp_value)))
        else $error("result dropped while stalled");
    ap_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !o_ready) else $error("ready while busy");
    ap_query_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && i_command == CMD_QUERY) |=> r_state == ST_VRD)
        else $error("query not started");
    ap_write_stays_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && i_command != CMD_QUERY) |=> r_state == ST_IDLE)
        else $error("write left idle");
endmodule
